/* rtl/core/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the shell line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Line status codes
  localparam logic [2:0] ST_READY  = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_EOI    = 3'd2;
  localparam logic [2:0] ST_QUOTES = 3'd3;
  localparam logic [2:0] ST_ESCAPE = 3'd4;

  // Character codes with special meaning
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Per-line tokenizer state
  typedef struct packed {
    logic quote_odd;
    logic quote_seen;
    logic after_backslash;
    logic word_has_chars;
    logic line_has_words;
    logic discarding;
  } slt_state_t;

  // One accepted input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } slt_item_t;

  // One result item
  typedef struct packed {
    logic       append_valid;
    logic [7:0] out_char;
    logic       word_end;
    logic       line_end;
    logic [2:0] line_status;
  } slt_result_t;

endpackage

/* rtl/core/shell_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Splits a command line, fed one character per item, into words.
// ----------------------------------------------------------------------------
// Each input item (a character byte, or an end-of-input mark on in_tuser)
// gives exactly one result item: a character to append, a word-end mark and,
// on tlast, a line end with status (ready, empty, end of input, unmatched
// quotes, bad escape). One item is taken per clock cycle while the output is
// not stalled; the accepted item lands in the input register, the step logic
// runs on it, and the result register loads once it is free or being drained.
// The tokenizer state is six flags updated together on each step, which sets
// the one-item-per-cycle rate. Both ports may stall freely.
// ----------------------------------------------------------------------------
module shell_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [10:8] line_status, rest 0
  output logic [1:0]  out_tuser,  // [0] append_valid, [1] word_end
  output logic        out_tlast   // line_end
);
  import slt_pkg::*;

  slt_item_t   in_item;
  slt_item_t   hold_item;
  logic        hold_valid;
  logic        advance;
  slt_result_t step_res;
  slt_result_t out_r;
  logic        out_valid_r;

  assign in_item.char_code    = in_tdata;
  assign in_item.end_of_input = in_tuser;

  // Step fires when the result register is free or being drained
  assign advance = hold_valid && (!out_valid_r || out_tready);

  slt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .hold_valid(hold_valid),
    .hold_take (advance),
    .hold_item (hold_item)
  );

  slt_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (hold_item),
    .result (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.line_status, out_r.out_char};
  assign out_tuser  = {out_r.word_end, out_r.append_valid};
  assign out_tlast  = out_r.line_end;

endmodule

/* rtl/core/slt_in_stage.sv */
// ----------------------------------------------------------------------------
// slt_in_stage
// Input register: holds one item until the step logic consumes it.
// ----------------------------------------------------------------------------
module slt_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slt_pkg::slt_item_t in_item,
  output logic              hold_valid,
  input  logic              hold_take,
  output slt_pkg::slt_item_t hold_item
);
  import slt_pkg::*;

  logic       valid_r;
  slt_item_t  item_r;

  // Free slot, or the held item leaves this cycle
  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/core/slt_step.sv */
// ----------------------------------------------------------------------------
// slt_step
// Tokenizer state register and the per-character decision logic.
// ----------------------------------------------------------------------------
module slt_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  slt_pkg::slt_item_t  item,
  output slt_pkg::slt_result_t result
);
  import slt_pkg::*;

  slt_state_t  state_r;
  slt_state_t  state_nxt;
  slt_result_t res;
  logic        ch_is_nl;
  logic        word_done;

  assign ch_is_nl  = (item.char_code == CH_NL);
  assign word_done = state_r.word_has_chars || state_r.quote_seen;

  always_comb begin
    state_nxt = state_r;
    res       = '0;
    if (state_r.discarding) begin
      // drop everything up to newline or end of input
      if (item.end_of_input) begin
        res.line_end    = 1'b1;
        res.line_status = ST_EOI;
        state_nxt       = '0;
      end else if (ch_is_nl) begin
        state_nxt = '0;
      end
    end else if (item.end_of_input) begin
      // partial word is dropped
      res.line_end = 1'b1;
      priority if (state_r.after_backslash) res.line_status = ST_ESCAPE;
      else if (state_r.quote_odd)           res.line_status = ST_QUOTES;
      else if (state_r.line_has_words)      res.line_status = ST_READY;
      else                                  res.line_status = ST_EOI;
      state_nxt = '0;
    end else if (state_r.after_backslash && item.char_code != CH_BSLASH &&
                 item.char_code != CH_DQUOTE) begin
      // bad escape: end line, discard the rest unless this is the newline
      res.line_end         = 1'b1;
      res.line_status      = ST_ESCAPE;
      state_nxt            = '0;
      state_nxt.discarding = !ch_is_nl;
    end else begin
      state_nxt.after_backslash = 1'b0;
      unique case (item.char_code)
        CH_DQUOTE: begin
          if (state_r.after_backslash) begin
            res.append_valid = 1'b1;
          end else begin
            state_nxt.quote_odd  = !state_r.quote_odd;
            state_nxt.quote_seen = 1'b1;
          end
        end
        CH_BSLASH: begin
          if (state_r.after_backslash) begin
            res.append_valid = 1'b1;
          end else begin
            state_nxt.after_backslash = 1'b1;
          end
        end
        CH_NL: begin
          res.word_end = !state_r.quote_odd && word_done;
          res.line_end = 1'b1;
          priority if (state_r.quote_odd)           res.line_status = ST_QUOTES;
          else if (state_r.line_has_words || word_done) res.line_status = ST_READY;
          else                                      res.line_status = ST_EMPTY;
          state_nxt = '0;
        end
        CH_SPACE, CH_TAB: begin
          if (state_r.quote_odd) begin
            res.append_valid = 1'b1;
          end else begin
            res.word_end = word_done;
            if (word_done) begin
              state_nxt.line_has_words = 1'b1;
            end
            state_nxt.word_has_chars = 1'b0;
            state_nxt.quote_seen     = 1'b0;
          end
        end
        default: begin
          res.append_valid = 1'b1;
        end
      endcase
      if (res.append_valid) begin
        res.out_char             = item.char_code;
        state_nxt.word_has_chars = 1'b1;
      end
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/slt_checker.sv */
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks for the shell line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // No character without append
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("char set without append");

  // Status only on line end, and within the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast || out_tdata[10:8] == 3'd0) &&
    out_tdata[10:8] != 3'd5 && out_tdata[10:8] != 3'd6 &&
    out_tdata[10:8] != 3'd7 && out_tdata[15:11] == 5'd0)
    else $error("bad line status");

  // Append never comes with a word or line end
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && !out_tlast)
    else $error("append mixed with word or line end");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
